// File: rtl/max_iou_box_matcher_macros.svh
// Assertion macros for the matcher RTL file
`ifndef MAX_IOU_BOX_MATCHER_MACROS_SVH
`define MAX_IOU_BOX_MATCHER_MACROS_SVH

`ifndef SYNTHESIS
// same-cycle implication
`define MIOU_ASSERT_IMP(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |-> (cons)) \
        else $error("miou: same-cycle check failed");
// next-cycle implication
`define MIOU_ASSERT_NXT(lbl, clk, rstn, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rstn) (ante) |=> (cons)) \
        else $error("miou: next-cycle check failed");
`else
`define MIOU_ASSERT_IMP(lbl, clk, rstn, ante, cons)
`define MIOU_ASSERT_NXT(lbl, clk, rstn, ante, cons)
`endif

`endif

// File: rtl/miou_pkg.sv
package miou_pkg;

    // IoU in unsigned Q1.16
    localparam int IOU_BITS     = 17;
    localparam int IOU_FRAC     = 16;
    localparam int DIV_CNT_BITS = $clog2(IOU_BITS);
    localparam logic [IOU_BITS-1:0] IOU_ONE = IOU_BITS'(1) << IOU_FRAC;

    // sequencer states
    typedef enum logic [3:0] {
        S_IDLE,
        S_EDGE,
        S_AREA_P,
        S_AREA_R,
        S_INTER,
        S_UNION,
        S_DIV,
        S_MAX
    } t_state;

    // divider status back to the sequencer
    typedef struct packed {
        logic busy;
        logic done;
    } t_div_status;

endpackage

// File: rtl/miou_if.sv
// box pair request channel
interface miou_box_if #(parameter int COORD_BITS = 12);
    logic                  valid;
    logic                  ready;
    logic [COORD_BITS-1:0] pred_x;
    logic [COORD_BITS-1:0] pred_y;
    logic [COORD_BITS-1:0] pred_w;
    logic [COORD_BITS-1:0] pred_h;
    logic [COORD_BITS-1:0] ref_x;
    logic [COORD_BITS-1:0] ref_y;
    logic [COORD_BITS-1:0] ref_w;
    logic [COORD_BITS-1:0] ref_h;
    logic                  last_box;

    modport source (
        output valid, pred_x, pred_y, pred_w, pred_h,
               ref_x, ref_y, ref_w, ref_h, last_box,
        input  ready
    );
    modport sink (
        input  valid, pred_x, pred_y, pred_w, pred_h,
               ref_x, ref_y, ref_w, ref_h, last_box,
        output ready
    );
endinterface

// best IoU result channel
interface miou_iou_if import miou_pkg::*; ();
    logic                valid;
    logic                ready;
    logic [IOU_BITS-1:0] best_iou;

    modport source (output valid, best_iou, input ready);
    modport sink   (input valid, best_iou, output ready);
endinterface

// File: rtl/max_iou_box_matcher.sv
// Per accepted box pair: accept, edge compute, three shared multiplier steps, union
// and divider start, 17 divider steps plus a done step, one compare step; then ready
// for the next pair. A last-of-set result is presented from the cycle the block is ready
// again; its compare step waits while the output slot holds a result not yet taken.
// Reset (synchronous, active low) clears the sequencer, the running maximum
// and the output valid flag.
`include "max_iou_box_matcher_macros.svh"

module max_iou_box_matcher import miou_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic        i_clk,
    input  logic        i_rst_n,
    miou_box_if.sink    i_box,
    miou_iou_if.source  o_iou
);

    localparam int AREA_BITS = 2 * COORD_BITS;
    localparam int UNI_BITS  = AREA_BITS + 1;
    localparam int EDGE_BITS = COORD_BITS + 1;

    t_state r_state, n_state;

    // request registers
    logic [COORD_BITS-1:0] r_px, r_py, r_pw, r_ph;
    logic [COORD_BITS-1:0] r_rx, r_ry, r_rw, r_rh;
    logic                  r_last;

    // intermediate results
    logic [COORD_BITS-1:0] r_iw, r_ih;
    logic [AREA_BITS-1:0]  r_area_p, r_area_r, r_inter;
    logic                  r_union_zero;
    logic [IOU_BITS-1:0]   r_best;
    logic [IOU_BITS-1:0]   r_out_iou;
    logic                  r_out_valid;

    // sequencer outputs
    logic in_ready;
    logic div_start;
    logic out_load;

    // overlap edges
    logic [EDGE_BITS-1:0]  p_right, r_right, p_bot, r_bot;
    logic [EDGE_BITS-1:0]  right, bottom, left, top;
    logic [EDGE_BITS-1:0]  dx, dy;
    logic [COORD_BITS-1:0] n_iw, n_ih;

    always_comb begin
        p_right = EDGE_BITS'(r_px) + EDGE_BITS'(r_pw);
        r_right = EDGE_BITS'(r_rx) + EDGE_BITS'(r_rw);
        p_bot   = EDGE_BITS'(r_py) + EDGE_BITS'(r_ph);
        r_bot   = EDGE_BITS'(r_ry) + EDGE_BITS'(r_rh);
        right   = (p_right < r_right) ? p_right : r_right;
        bottom  = (p_bot < r_bot) ? p_bot : r_bot;
        left    = EDGE_BITS'((r_px > r_rx) ? r_px : r_rx);
        top     = EDGE_BITS'((r_py > r_ry) ? r_py : r_ry);
        dx      = right - left;
        dy      = bottom - top;
        // overlap never exceeds either width, so it fits COORD_BITS
        n_iw    = (right > left) ? dx[COORD_BITS-1:0] : '0;
        n_ih    = (bottom > top) ? dy[COORD_BITS-1:0] : '0;
    end

    // shared multiplier, operands picked by the sequencer
    logic [COORD_BITS-1:0] mul_a, mul_b;
    logic [AREA_BITS-1:0]  mul_p;

    always_comb begin
        case (r_state)
            S_AREA_P: begin
                mul_a = r_pw;
                mul_b = r_ph;
            end
            S_AREA_R: begin
                mul_a = r_rw;
                mul_b = r_rh;
            end
            default: begin
                mul_a = r_iw;
                mul_b = r_ih;
            end
        endcase
    end

    assign mul_p = AREA_BITS'(mul_a) * AREA_BITS'(mul_b);

    // union area
    logic [UNI_BITS-1:0] uni_sum;
    assign uni_sum = UNI_BITS'(r_area_p) + UNI_BITS'(r_area_r) - UNI_BITS'(r_inter);

    // divider
    t_div_status         div_status;
    logic [IOU_BITS-1:0] div_quot;

    miou_div #(
        .COORD_BITS (COORD_BITS)
    ) u_div (
        .i_clk      (i_clk),
        .i_rst_n    (i_rst_n),
        .i_start    (div_start),
        .i_dividend (r_inter),
        .i_divisor  (uni_sum),
        .o_status   (div_status),
        .o_quot     (div_quot)
    );

    // candidate and running maximum
    logic [IOU_BITS-1:0] cur_iou, best_iou;
    always_comb begin
        cur_iou  = r_union_zero ? '0 : div_quot;
        best_iou = (cur_iou > r_best) ? cur_iou : r_best;
    end

    // state register
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_state <= S_IDLE;
        end else begin
            r_state <= n_state;
        end
    end

    // next state and sequencer outputs
    always_comb begin
        n_state   = r_state;
        in_ready  = 1'b0;
        div_start = 1'b0;
        out_load  = 1'b0;
        case (r_state)
            S_IDLE: begin
                in_ready = 1'b1;
                if (i_box.valid) begin
                    n_state = S_EDGE;
                end
            end
            S_EDGE:   n_state = S_AREA_P;
            S_AREA_P: n_state = S_AREA_R;
            S_AREA_R: n_state = S_INTER;
            S_INTER:  n_state = S_UNION;
            S_UNION: begin
                div_start = 1'b1;
                n_state   = S_DIV;
            end
            S_DIV: begin
                if (div_status.done) begin
                    n_state = S_MAX;
                end
            end
            S_MAX: begin
                if (!r_last) begin
                    n_state = S_IDLE;
                end else if (!r_out_valid || o_iou.ready) begin
                    out_load = 1'b1;
                    n_state  = S_IDLE;
                end
            end
            default: n_state = S_IDLE;
        endcase
    end

    // running maximum and output slot
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_best      <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (out_load) begin
                r_out_valid <= 1'b1;
            end else if (o_iou.ready) begin
                r_out_valid <= 1'b0;
            end
            if (r_state == S_MAX) begin
                if (!r_last) begin
                    r_best <= best_iou;
                end else if (out_load) begin
                    r_best <= '0;
                end
            end
        end
    end

    // datapath registers
    always_ff @(posedge i_clk) begin
        if (in_ready && i_box.valid) begin
            r_px   <= i_box.pred_x;
            r_py   <= i_box.pred_y;
            r_pw   <= i_box.pred_w;
            r_ph   <= i_box.pred_h;
            r_rx   <= i_box.ref_x;
            r_ry   <= i_box.ref_y;
            r_rw   <= i_box.ref_w;
            r_rh   <= i_box.ref_h;
            r_last <= i_box.last_box;
        end
        if (r_state == S_EDGE) begin
            r_iw <= n_iw;
            r_ih <= n_ih;
        end
        if (r_state == S_AREA_P) begin
            r_area_p <= mul_p;
        end
        if (r_state == S_AREA_R) begin
            r_area_r <= mul_p;
        end
        if (r_state == S_INTER) begin
            r_inter <= mul_p;
        end
        if (r_state == S_UNION) begin
            r_union_zero <= (uni_sum == '0);
        end
        if (out_load) begin
            r_out_iou <= best_iou;
        end
    end

    assign i_box.ready    = in_ready;
    assign o_iou.valid    = r_out_valid;
    assign o_iou.best_iou = r_out_iou;

    // checks
    `MIOU_ASSERT_IMP(a_ready_div_idle, i_clk, i_rst_n, i_box.ready, !div_status.busy)
    `MIOU_ASSERT_IMP(a_inter_in_areas, i_clk, i_rst_n, r_state == S_UNION,
        (r_inter <= r_area_p) && (r_inter <= r_area_r))
    `MIOU_ASSERT_IMP(a_quot_range, i_clk, i_rst_n, div_status.done && !r_union_zero,
        div_quot <= IOU_ONE)
    `MIOU_ASSERT_NXT(a_clear_on_emit, i_clk, i_rst_n, out_load, (r_best == '0) && o_iou.valid)

endmodule

// File: rtl/miou_div.sv
// Serial restoring divider: one quotient bit per cycle, IOU_BITS quotient bits.
// Dividend must not exceed the divisor; the first step takes the integer bit.
module miou_div import miou_pkg::*; #(
    parameter int COORD_BITS = 12
) (
    input  logic                      i_clk,
    input  logic                      i_rst_n,
    input  logic                      i_start,
    input  logic [2*COORD_BITS-1:0]   i_dividend,
    input  logic [2*COORD_BITS:0]     i_divisor,
    output t_div_status               o_status,
    output logic [IOU_BITS-1:0]       o_quot
);

    localparam int UNI_BITS = 2 * COORD_BITS + 1;
    localparam int REM_BITS = UNI_BITS + 1;

    logic [REM_BITS-1:0]     r_rem;
    logic [UNI_BITS-1:0]     r_div;
    logic [IOU_BITS-1:0]     r_quot;
    logic [DIV_CNT_BITS-1:0] r_cnt;
    logic                    r_first;
    logic                    r_busy;
    logic                    r_done;

    logic [REM_BITS-1:0] trial;
    logic                fits;

    // trial subtract: first step unshifted, then shift one bit in
    always_comb begin
        trial = r_first ? r_rem : {r_rem[REM_BITS-2:0], 1'b0};
        fits  = (trial >= REM_BITS'(r_div));
    end

    // control
    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_busy <= 1'b0;
            r_done <= 1'b0;
        end else begin
            r_done <= 1'b0;
            if (i_start) begin
                r_busy <= 1'b1;
            end else if (r_busy && r_cnt == DIV_CNT_BITS'(IOU_BITS - 1)) begin
                r_busy <= 1'b0;
                r_done <= 1'b1;
            end
        end
    end

    // datapath
    always_ff @(posedge i_clk) begin
        if (i_start) begin
            r_rem   <= REM_BITS'(i_dividend);
            r_div   <= i_divisor;
            r_cnt   <= '0;
            r_first <= 1'b1;
        end else if (r_busy) begin
            r_rem   <= fits ? (trial - REM_BITS'(r_div)) : trial;
            r_quot  <= {r_quot[IOU_BITS-2:0], fits};
            r_cnt   <= r_cnt + 1'b1;
            r_first <= 1'b0;
        end
    end

    assign o_status.busy = r_busy;
    assign o_status.done = r_done;
    assign o_quot        = r_quot;

endmodule
